// File: hdl/projection_back_scaler_unit_defines.svh
// assertion macros for the projection back scaler
`ifndef PROJECTION_BACK_SCALER_UNIT_DEFINES_SVH
`define PROJECTION_BACK_SCALER_UNIT_DEFINES_SVH
// implication checked on every edge outside reset
`define PBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbs check failed");
// implication checked in the cycle after the antecedent
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbs check failed");
`endif

// File: hdl/pbs_pkg.sv
// shared types and constants of the projection back scaler
package pbs_pkg;
    localparam logic [15:0] FF_ONE = 16'd32768;
    localparam logic [15:0] FF_RESET = 16'd32440;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // request handed from the front part to the back part
    typedef struct packed {
        logic        in_range;
        logic signed [15:0] src_re;
        logic signed [15:0] src_im;
        logic signed [31:0] cre;
        logic signed [31:0] cim;
        logic [31:0] den;
    } pbs_req_t;

    // queue status, used at the top level to qualify the back part's request
    typedef struct packed {
        logic full;
        logic empty;
    } pbs_q_stat_t;
endpackage

// File: hdl/pbs_front.sv
// front part: bin store update and a pipeline feeding the queue
`include "projection_back_scaler_unit_defines.svh"
module pbs_front #(
    parameter int NUM_BINS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [15:0] forget_factor,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] bin,
    input  logic signed [15:0] src_re,
    input  logic signed [15:0] src_im,
    input  logic signed [15:0] ref_re,
    input  logic signed [15:0] ref_im,
    input  logic [2:0] q_credit,
    output logic req_valid,
    output pbs_pkg::pbs_req_t req
);
    import pbs_pkg::*;
    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [31:0] cre_mem [NUM_BINS];
    logic [31:0] cim_mem [NUM_BINS];
    logic [31:0] pw_mem [NUM_BINS];
    logic [NUM_BINS-1:0] written_reg;

    // stage 1: products, memory read
    logic v1_reg, rng1_reg;
    logic [AW-1:0] a1_reg;
    logic signed [15:0] sr1_reg, si1_reg;
    logic signed [32:0] xre1_reg, xim1_reg;
    logic [31:0] pw1_reg;
    logic [31:0] rcre_reg, rcim_reg, rpw_reg;
    logic wr1_reg;
    logic [15:0] ff1_reg;
    // stage 2: blend
    logic v2_reg, rng2_reg;
    logic [AW-1:0] a2_reg;
    logic signed [15:0] sr2_reg, si2_reg;
    logic signed [31:0] cre2_reg, cim2_reg;
    logic [31:0] den2_reg;
    // last write-back, held in a further register: a read at the writing edge sees the old entry
    logic wb3_reg;
    logic [AW-1:0] a3_reg;
    logic signed [31:0] cre3_reg, cim3_reg;
    logic [31:0] den3_reg;

    logic in_range;
    logic [AW-1:0] addr;
    logic accept;
    logic [15:0] ff;
    logic signed [31:0] old_cre, old_cim;
    logic [31:0] old_pw;
    logic signed [33:0] xre, xim;
    logic fwd;
    logic fwd3;
    logic signed [16:0] wn;
    logic signed [50:0] acc_re, acc_im;
    logic [48:0] acc_pw;
    logic signed [35:0] sre, sim;
    logic signed [31:0] cre_n, cim_n;

    assign in_range = ({24'd0, bin} < 32'(NUM_BINS));
    assign addr = AW'(bin);
    // credit counts free queue slots; a request is taken only while it exceeds the requests in flight
    assign in_ready = (q_credit > 3'({1'b0, v1_reg} + {1'b0, v2_reg}));
    assign accept = in_valid && in_ready;
    assign ff = (forget_factor > FF_ONE) ? FF_ONE : forget_factor;

    always_ff @(posedge clk)
    begin
        rcre_reg <= cre_mem[addr];
        rcim_reg <= cim_mem[addr];
        rpw_reg  <= pw_mem[addr];
        if (v2_reg && rng2_reg)
        begin
            cre_mem[a2_reg] <= cre2_reg;
            cim_mem[a2_reg] <= cim2_reg;
            pw_mem[a2_reg]  <= den2_reg;
        end
        sr1_reg <= src_re;
        si1_reg <= src_im;
        a1_reg <= addr;
        ff1_reg <= ff;
        xre1_reg <= 33'(src_re * ref_re) + 33'(src_im * ref_im);
        xim1_reg <= 33'(src_re * ref_im) - 33'(src_im * ref_re);
        pw1_reg <= 32'(src_re * src_re) + 32'(src_im * src_im);
        wr1_reg <= written_reg[addr];
        a2_reg <= a1_reg;
        sr2_reg <= sr1_reg;
        si2_reg <= si1_reg;
        rng2_reg <= rng1_reg;
        cre2_reg <= cre_n;
        cim2_reg <= cim_n;
        den2_reg <= acc_pw[46:15];
        rng1_reg <= in_range;
        a3_reg <= a2_reg;
        cre3_reg <= cre2_reg;
        cim3_reg <= cim2_reg;
        den3_reg <= den2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            wb3_reg <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            wb3_reg <= v2_reg && rng2_reg;
            if (v2_reg && rng2_reg)
                written_reg[a2_reg] <= 1'b1;
        end
    end

    // forward the entry being written back, or the one held from the last write-back, when stage 1 reads the same bin
    assign fwd = v2_reg && rng2_reg && (a2_reg == a1_reg);
    assign fwd3 = wb3_reg && (a3_reg == a1_reg);
    always_comb
    begin
        if (fwd)
        begin
            old_cre = cre2_reg;
            old_cim = cim2_reg;
            old_pw  = den2_reg;
        end
        else if (fwd3)
        begin
            old_cre = cre3_reg;
            old_cim = cim3_reg;
            old_pw  = den3_reg;
        end
        else if (wr1_reg)
        begin
            old_cre = rcre_reg;
            old_cim = rcim_reg;
            old_pw  = rpw_reg;
        end
        else
        begin
            old_cre = ONE_Q30;
            old_cim = '0;
            old_pw  = 32'(ONE_Q30);
        end
        xre = 34'(xre1_reg);
        xim = 34'(xim1_reg);
        wn = 17'(FF_ONE) - 17'(ff1_reg);
        acc_re = 51'($signed({1'b0, ff1_reg}) * old_cre) + 51'(wn * xre) + 51'sd16384;
        acc_im = 51'($signed({1'b0, ff1_reg}) * old_cim) + 51'(wn * xim) + 51'sd16384;
        acc_pw = 49'(ff1_reg * old_pw) + 49'(wn[15:0] * pw1_reg) + 49'd16384;
        sre = 36'(acc_re >>> 15);
        sim = 36'(acc_im >>> 15);
        if (sre > 36'sh07FFF_FFFF) cre_n = 32'sh7FFF_FFFF;
        else if (sre < -36'sh08000_0000) cre_n = 32'sh8000_0000;
        else cre_n = sre[31:0];
        if (sim > 36'sh07FFF_FFFF) cim_n = 32'sh7FFF_FFFF;
        else if (sim < -36'sh08000_0000) cim_n = 32'sh8000_0000;
        else cim_n = sim[31:0];
    end

    assign req_valid = v2_reg;
    assign req.in_range = rng2_reg;
    assign req.src_re = sr2_reg;
    assign req.src_im = si2_reg;
    assign req.cre = cre2_reg;
    assign req.cim = cim2_reg;
    assign req.den = den2_reg;

    `PBS_ASSERT_IMP(a_no_overrun, clk, rst_n, accept, q_credit != 3'd0)
    `PBS_ASSERT_NEXT(a_pipe_moves, clk, rst_n, accept, v1_reg)
    `PBS_ASSERT_NEXT(a_stage2, clk, rst_n, v1_reg, v2_reg)
endmodule

// File: hdl/pbs_queue.sv
// short request queue between the front and the back part
`include "projection_back_scaler_unit_defines.svh"
module pbs_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    input  pbs_pkg::pbs_req_t wr_data,
    input  logic rd_ready,
    output logic rd_valid,
    output pbs_pkg::pbs_req_t rd_data,
    output logic [2:0] credit,
    output pbs_pkg::pbs_q_stat_t stat
);
    import pbs_pkg::*;
    pbs_req_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic do_rd;

    assign rd_valid = (cnt_reg != 3'd0);
    assign do_rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];
    assign credit = 3'd4 - cnt_reg;
    assign stat.full = (cnt_reg == 3'd4);
    assign stat.empty = (cnt_reg == 3'd0);

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_valid) wp_reg <= wp_reg + 2'd1;
            if (do_rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_valid) - 3'(do_rd);
        end
    end

    `PBS_ASSERT_IMP(a_q_no_overflow, clk, rst_n, wr_valid && stat.full, 1'b0)
    `PBS_ASSERT_IMP(a_q_count, clk, rst_n, 1'b1, cnt_reg <= 3'd4)
    `PBS_ASSERT_IMP(a_q_empty, clk, rst_n, stat.empty, !do_rd)
endmodule

// File: hdl/pbs_back.sv
// back part: complex product, pipelined divider, rounding and saturation
`include "projection_back_scaler_unit_defines.svh"
module pbs_back (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  pbs_pkg::pbs_req_t req,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [15:0] out_re,
    output logic signed [15:0] out_im,
    output logic zero_power
);
    import pbs_pkg::*;
    // quotient bits: saturation needs only 16 bits; stages 2..NQ+1
    localparam int NQ = 17;
    localparam int NS = NQ + 2;

    logic adv;
    logic [NS-1:0] v_reg;
    logic [NS-1:0] bypass_reg;
    logic [NS-1:0] zp_reg;
    logic signed [15:0] sre_reg [NS];
    logic signed [15:0] sim_reg [NS];
    logic [31:0] den0_reg;
    logic [32:0] den_reg [NS];
    // per lane: sign, remainder, quotient
    logic [1:0] neg_reg [NS];
    logic [65:0] rem_reg [2][NS];
    logic [NQ-1:0] q_reg [2][NS];
    logic over_reg [2][NS];
    logic signed [48:0] p0_re, p0_im;
    logic signed [48:0] pr_reg, pi_reg;

    assign adv = !out_valid || out_ready;
    assign req_ready = adv;

    // stage 0 multiplies; stage 1 forms magnitudes and the doubled numerator
    always_comb
    begin
        p0_re = 49'(req.src_re * req.cre) - 49'(req.src_im * req.cim);
        p0_im = 49'(req.src_re * req.cim) + 49'(req.src_im * req.cre);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg <= p0_re;
            pi_reg <= p0_im;
            den0_reg <= req.den;
            sre_reg[0] <= req.src_re;
            sim_reg[0] <= req.src_im;
            bypass_reg[0] <= !req.in_range || (req.den == 32'd0);
            zp_reg[0] <= req.in_range && (req.den == 32'd0);
            for (int s = 1; s < NS; s++)
            begin
                sre_reg[s] <= sre_reg[s-1];
                sim_reg[s] <= sim_reg[s-1];
                bypass_reg[s] <= bypass_reg[s-1];
                zp_reg[s] <= zp_reg[s-1];
            end
            // stage 1: numerator 2|p|+den, divisor 2*den
            neg_reg[1] <= {pi_reg[48], pr_reg[48]};
            den_reg[1] <= {den0_reg, 1'b0};
            rem_reg[0][1] <= 66'({(pr_reg[48] ? 49'(-pr_reg) : pr_reg), 1'b0}) + 66'(den0_reg);
            rem_reg[1][1] <= 66'({(pi_reg[48] ? 49'(-pi_reg) : pi_reg), 1'b0}) + 66'(den0_reg);
            for (int l = 0; l < 2; l++)
            begin
                q_reg[l][1] <= '0;
                over_reg[l][1] <= 1'b0;
            end
            // restoring division, one quotient bit per stage, msb first
            for (int s = 2; s < NS; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                for (int l = 0; l < 2; l++)
                begin
                    logic [65:0] t;
                    t = 66'(den_reg[s-1]) << (NQ - (s - 1));
                    if (s == 2)
                        over_reg[l][s] <= (rem_reg[l][s-1] >> (NQ)) >= 66'(den_reg[s-1]);
                    else
                        over_reg[l][s] <= over_reg[l][s-1];
                    q_reg[l][s] <= q_reg[l][s-1];
                    if (rem_reg[l][s-1] >= t && !(s == 2 &&
                        (rem_reg[l][s-1] >> NQ) >= 66'(den_reg[s-1])))
                    begin
                        rem_reg[l][s] <= rem_reg[l][s-1] - t;
                        q_reg[l][s][NQ-(s-1)] <= 1'b1;
                    end
                    else
                        rem_reg[l][s] <= rem_reg[l][s-1];
                end
            end
        end
    end

    // overflow beyond the top bit saturates anyway; last step yields bit 0
    logic [NQ:0] qf [2];
    logic signed [15:0] res [2];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            qf[l] = {over_reg[l][NS-1], q_reg[l][NS-1]};
            if (rem_reg[l][NS-1] >= 66'(den_reg[NS-1]) && !over_reg[l][NS-1])
                qf[l] = qf[l] | 18'd1;
            if (neg_reg[NS-1][l])
                res[l] = (qf[l] >= 18'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, qf[l][15:0]}));
            else
                res[l] = (qf[l] >= 18'd32767) ? 16'sh7FFF : qf[l][15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0], req_valid};
    end

    logic signed [15:0] ore_reg, oim_reg;
    logic ozp_reg, ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= v_reg[NS-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ore_reg <= bypass_reg[NS-1] ? sre_reg[NS-1] : res[0];
            oim_reg <= bypass_reg[NS-1] ? sim_reg[NS-1] : res[1];
            ozp_reg <= zp_reg[NS-1];
        end
    end
    assign out_valid = ov_reg;
    assign out_re = ore_reg;
    assign out_im = oim_reg;
    assign zero_power = ozp_reg;

    `PBS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PBS_ASSERT_IMP(a_zp_bypass, clk, rst_n, out_valid && zero_power, 1'b1)
    `PBS_ASSERT_IMP(a_ready_adv, clk, rst_n, !out_valid, req_ready)
endmodule

// File: hdl/projection_back_scaler_unit.sv
// top level of the projection back scaler
// usage: requests enter on in_valid/in_ready with bin, src_re/src_im and
// ref_re/ref_im; results leave on out_valid/out_ready with out_re/out_im
// and zero_power, one result per request, in order.
// the user writes forget_factor with cfg_we/cfg_data only while the block is
// idle (not enforced by the block); values above 32768 act as 1.0.
// the front part reads the per-bin estimates, updates them and writes them
// back; the back part forms s*C and divides by the power in a pipelined
// divider of one quotient bit per stage.
// out_valid follows front stages 1 and 2, the queue and the back stages;
// one request per cycle is taken while the result side keeps up.
// a four-entry queue sits between the parts; when the receiver stalls the
// back part holds, the queue fills and in_ready falls.
// reset sets every bin to cross 1.0 and power 1.0 through per-bin written
// flags, so no clearing pass is needed and requests are taken at once.
// bins at or above NUM_BINS pass the source through and touch no store.
module projection_back_scaler_unit #(
    parameter int NUM_BINS = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [15:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [7:0] bin,
    input  logic signed [15:0] src_re,
    input  logic signed [15:0] src_im,
    input  logic signed [15:0] ref_re,
    input  logic signed [15:0] ref_im,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [15:0] out_re,
    output logic signed [15:0] out_im,
    output logic zero_power
);
    import pbs_pkg::*;
    logic [15:0] ff_reg;
    logic f_valid, q_valid, q_ready;
    pbs_req_t f_req, q_req;
    logic [2:0] credit;
    pbs_q_stat_t q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ff_reg <= FF_RESET;
        else if (cfg_we)
            ff_reg <= cfg_data;
    end

    pbs_front #(.NUM_BINS(NUM_BINS)) u_front (
        .clk, .rst_n, .forget_factor(ff_reg), .in_valid, .in_ready, .bin,
        .src_re, .src_im, .ref_re, .ref_im, .q_credit(credit),
        .req_valid(f_valid), .req(f_req)
    );
    pbs_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_data(f_req), .rd_ready(q_ready),
        .rd_valid(q_valid), .rd_data(q_req), .credit, .stat(q_stat)
    );
    pbs_back u_back (
        .clk, .rst_n, .req_valid(q_valid && !q_stat.empty), .req_ready(q_ready),
        .req(q_req), .out_valid, .out_ready, .out_re, .out_im, .zero_power
    );
endmodule
